// ----- design/length_prefixed_frame_parser_defines.svh -----
// Assertion macros shared by the frame parser modules.
// No dependencies; included by the files that carry assertions.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lpfp_pkg.sv -----
// Types and constants of the length-prefixed frame parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lpfp_pkg;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SESS_LEN_MAX = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAY_LEN_MAX  = 4'd1;

   localparam logic [31:0] SESS_LEN_MAX_RESET = 32'd64;
   localparam logic [31:0] PAY_LEN_MAX_RESET  = 32'd65536;

   // result kinds
   localparam logic [2:0] KIND_SESSION  = 3'd0;
   localparam logic [2:0] KIND_SENDER   = 3'd1;
   localparam logic [2:0] KIND_RECEIVER = 3'd2;
   localparam logic [2:0] KIND_TYPE     = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd4;
   localparam logic [2:0] KIND_ACCEPT   = 3'd5;
   localparam logic [2:0] KIND_ERROR    = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED    = 3'd1;
   localparam logic [2:0] ERR_SESS_LONG    = 3'd2;
   localparam logic [2:0] ERR_SESS_OVERRUN = 3'd3;
   localparam logic [2:0] ERR_PAY_LONG     = 3'd4;
   localparam logic [2:0] ERR_PAY_OVERRUN  = 3'd5;
   localparam logic [2:0] ERR_TRAILING     = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } lpfp_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [2:0]  error_code;
      logic        last_of_run;
   } lpfp_rsp_type;

   // up to two results produced by one input word
   typedef struct packed {
      logic [1:0]   count;
      lpfp_rsp_type first;
      lpfp_rsp_type second;
   } lpfp_res_type;

endpackage

// ----- design/length_prefixed_frame_parser.sv -----
// Top level of the length-prefixed frame parser: input register, CSRs, core, result queue.
// Depends on lpfp_pkg, lpfp_core, lpfp_rsp_fifo and the assertion macro header.
//
// Usage:
//   req_*  : one message byte per word with an end-of-buffer flag; taken when
//            req_valid is high and req_stall is low.
//   rsp_*  : result words (session/payload bytes, header words, accept or error);
//            taken when rsp_valid is high and rsp_stall is low. last_of_run
//            marks the final result caused by one input byte.
//   csr_*  : register writes (index 0 max session length, 1 max payload length),
//            always ready; write only while the block is idle.
// Path: a byte is registered in the input register, decoded by the core and its
//   results are written into the result queue, which drives rsp_*.
// Throughput: one byte per cycle while the consumer keeps up; a byte that makes
//   two results needs two pops at the output port, so the result queue sets the
//   sustained rate when many such bytes arrive back to back.
// Reset: parser returns to the session length word, queue empties, registers
//   take 64 and 65536.
// Receiver stall: results wait in the queue; once fewer than two entries are
//   free, the input register holds and req_stall rises.
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_defines.svh"

module length_prefixed_frame_parser #(
   parameter int unsigned RSP_FIFO_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lpfp_pkg::lpfp_req_type                 req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lpfp_pkg::lpfp_rsp_type                 rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lpfp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [31:0]                            csr_data
);
   import lpfp_pkg::*;

   logic         in_vld_ff, in_vld_in;
   lpfp_req_type in_item_ff;
   logic [31:0]  max_sess_ff, max_pay_ff;
   logic         room;
   logic         advance;
   logic         req_take;
   lpfp_res_type res;

   assign csr_ready = 1'b1;
   assign advance   = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         max_sess_ff <= SESS_LEN_MAX_RESET;
         max_pay_ff  <= PAY_LEN_MAX_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SESS_LEN_MAX: max_sess_ff <= csr_data;
               CSR_PAY_LEN_MAX:  max_pay_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // hold the word while the queue is short of room
   always_ff @(posedge clock) begin
      if (req_take) in_item_ff <= req_payload;
   end

   lpfp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (in_item_ff),
      .sess_len_max (max_sess_ff),
      .pay_len_max  (max_pay_ff),
      .res          (res)
   );

   lpfp_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (res),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `LPFP_ASSERT_NXT(a_input_held, clock, reset, in_vld_ff && !room,
                    in_vld_ff && $stable(in_item_ff), "stalled input word changed")

endmodule

// ----- design/lpfp_core.sv -----
// Parser state and per-word decode of the length-prefixed frame parser.
// Depends on lpfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_defines.svh"

module lpfp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lpfp_pkg::lpfp_req_type item,
   input  logic [31:0]          sess_len_max,
   input  logic [31:0]          pay_len_max,
   output lpfp_pkg::lpfp_res_type res
);
   import lpfp_pkg::*;

   typedef enum logic [7:0] {
      PH_SLEN = 8'b0000_0001,
      PH_SESS = 8'b0000_0010,
      PH_FROM = 8'b0000_0100,
      PH_TO   = 8'b0000_1000,
      PH_TYPE = 8'b0001_0000,
      PH_PLEN = 8'b0010_0000,
      PH_PAY  = 8'b0100_0000,
      PH_DONE = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [23:0] shift_ff, shift_in;
   logic [31:0] remain_ff, remain_in;
   logic        disc_ff, disc_in;

   logic [31:0]  word;
   logic         word_done;
   logic [31:0]  remain_dec;
   logic         is_sess;
   logic [31:0]  limit;
   logic [2:0]   code;
   logic         accept;
   logic         data_vld;
   logic [2:0]   data_kind;
   logic [31:0]  data_val;
   logic         fin_vld;
   lpfp_rsp_type data_rsp;
   lpfp_rsp_type fin_rsp;

   assign word       = {shift_ff, item.data_byte};
   assign word_done  = (cnt_ff == 2'd3);
   assign remain_dec = remain_ff - 32'd1;
   assign is_sess    = (phase_ff == PH_SLEN) || (phase_ff == PH_SESS);
   assign limit      = is_sess ? sess_len_max : pay_len_max;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      remain_in = remain_ff;
      disc_in   = disc_ff;
      code      = ERR_NONE;
      accept    = 1'b0;
      data_vld  = 1'b0;
      data_kind = KIND_SESSION;
      data_val  = '0;
      if (fire && !disc_ff) begin
         case (phase_ff)
            PH_SLEN, PH_PLEN: begin
               if (!word_done) begin
                  cnt_in   = cnt_ff + 2'd1;
                  shift_in = word[23:0];
                  if (item.end_of_buffer) code = ERR_TRUNCATED;
               end else begin
                  cnt_in   = 2'd0;
                  shift_in = '0;
                  if (word > limit) begin
                     code = is_sess ? ERR_SESS_LONG : ERR_PAY_LONG;
                  end else if (word == 32'd0) begin
                     // empty field: skip straight past it
                     phase_in = is_sess ? PH_FROM : PH_DONE;
                     if (item.end_of_buffer) begin
                        if (is_sess) code = ERR_TRUNCATED;
                        else accept = 1'b1;
                     end
                  end else begin
                     remain_in = word;
                     phase_in  = is_sess ? PH_SESS : PH_PAY;
                     if (item.end_of_buffer) code = is_sess ? ERR_SESS_OVERRUN : ERR_PAY_OVERRUN;
                  end
               end
            end
            PH_SESS, PH_PAY: begin
               data_vld  = 1'b1;
               data_kind = is_sess ? KIND_SESSION : KIND_PAYLOAD;
               data_val  = {24'd0, item.data_byte};
               remain_in = remain_dec;
               if (remain_dec == 32'd0) phase_in = is_sess ? PH_FROM : PH_DONE;
               if (item.end_of_buffer) begin
                  if (remain_dec != 32'd0) code = is_sess ? ERR_SESS_OVERRUN : ERR_PAY_OVERRUN;
                  else if (is_sess) code = ERR_TRUNCATED;
                  else accept = 1'b1;
               end
            end
            PH_FROM, PH_TO, PH_TYPE: begin
               if (!word_done) begin
                  cnt_in   = cnt_ff + 2'd1;
                  shift_in = word[23:0];
               end else begin
                  cnt_in   = 2'd0;
                  shift_in = '0;
                  data_vld = 1'b1;
                  data_val = word;
                  if (phase_ff == PH_FROM) begin
                     data_kind = KIND_SENDER;
                     phase_in  = PH_TO;
                  end else if (phase_ff == PH_TO) begin
                     data_kind = KIND_RECEIVER;
                     phase_in  = PH_TYPE;
                  end else begin
                     data_kind = KIND_TYPE;
                     phase_in  = PH_PLEN;
                  end
               end
               if (item.end_of_buffer) code = ERR_TRUNCATED;
            end
            default: begin
               code = ERR_TRAILING;
            end
         endcase
      end

      // restart on a flagged byte that ends the message or the discard run
      if (fire) begin
         if (disc_ff || code != ERR_NONE || accept) begin
            if (item.end_of_buffer || accept) begin
               phase_in  = PH_SLEN;
               cnt_in    = 2'd0;
               shift_in  = '0;
               remain_in = '0;
               disc_in   = 1'b0;
            end else begin
               disc_in = 1'b1;
            end
         end
      end
   end

   assign fin_vld = fire && !disc_ff && (code != ERR_NONE || accept);

   always_comb begin
      data_rsp.kind        = data_kind;
      data_rsp.value       = data_val;
      data_rsp.error_code  = ERR_NONE;
      data_rsp.last_of_run = !fin_vld;
      fin_rsp.kind         = (code != ERR_NONE) ? KIND_ERROR : KIND_ACCEPT;
      fin_rsp.value        = '0;
      fin_rsp.error_code   = code;
      fin_rsp.last_of_run  = 1'b1;
      res = '0;
      if (fire && !disc_ff) begin
         if (data_vld) begin
            res.first  = data_rsp;
            res.second = fin_rsp;
            res.count  = fin_vld ? 2'd2 : 2'd1;
         end else begin
            res.first = fin_rsp;
            res.count = fin_vld ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SLEN;
         cnt_ff    <= 2'd0;
         shift_ff  <= '0;
         remain_ff <= '0;
         disc_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         shift_ff  <= shift_in;
         remain_ff <= remain_in;
         disc_ff   <= disc_in;
      end
   end

   `LPFP_ASSERT_IMP(a_discard_silent, clock, reset, fire && disc_ff, res.count == 2'd0,
                    "discarded word produced a result")
   `LPFP_ASSERT_IMP(a_pair_ends_msg, clock, reset, res.count == 2'd2,
                    res.second.kind == KIND_ERROR || res.second.kind == KIND_ACCEPT,
                    "second result is not a verdict")

endmodule

// ----- design/lpfp_rsp_fifo.sv -----
// Result queue of the frame parser: takes up to two results a cycle, gives one while rsp_stall is low.
// Depends on lpfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_defines.svh"

module lpfp_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpfp_pkg::lpfp_res_type push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lpfp_pkg::lpfp_rsp_type rsp_payload
);
   import lpfp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lpfp_rsp_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PTR_W-1:0]      wr_next;
   logic                  pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_next     = ptr_next(wr_ff);
   assign room        = cnt_ff <= CNT_W'(DEPTH - 2);
   assign rsp_valid   = cnt_ff != '0;
   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_payload = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      case (push.count)
         2'd1:    wr_in = wr_next;
         2'd2:    wr_in = ptr_next(wr_next);
         default: wr_in = wr_ff;
      endcase
      rd_in  = pop ? ptr_next(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push.count != 2'd0 && wr_ff == PTR_W'(i)) mem_ff[i] <= push.first;
         if (push.count == 2'd2 && wr_next == PTR_W'(i)) mem_ff[i] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `LPFP_ASSERT_IMP(a_push_fits, clock, reset, push.count != 2'd0,
                    cnt_ff <= CNT_W'(DEPTH - 2), "push into a queue without room")
   `LPFP_ASSERT_NXT(a_count_track, clock, reset, pop && push.count == 2'd0,
                    cnt_ff == $past(cnt_ff) - CNT_W'(1), "queue count lost a pop")

endmodule
